// ===== hdl/lex_tok_pkg.sv =====
// package for the lexical tokenizer: payload structs, token kind codes,
// character classes and keyword match helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lex_tok_pkg;

    localparam int MAX_LEXEME_LEN = 128;
    localparam int POS_W          = 16;
    localparam int LEN_W          = 8;
    localparam int KIND_W         = 5;
    localparam int KW_COUNT       = 3;
    localparam int KW_MAX_CHARS   = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEXEME_LEN);

    // token kind codes
    localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IF        = 5'd1;
    localparam logic [KIND_W-1:0] KIND_ELSE      = 5'd2;
    localparam logic [KIND_W-1:0] KIND_WHILE     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_INT       = 5'd4;
    localparam logic [KIND_W-1:0] KIND_FLOAT     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd6;
    localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd7;
    localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd8;
    localparam logic [KIND_W-1:0] KIND_MUL       = 5'd9;
    localparam logic [KIND_W-1:0] KIND_DIV       = 5'd10;
    localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd14;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd15;
    localparam logic [KIND_W-1:0] KIND_SEMICOLON = 5'd16;
    localparam logic [KIND_W-1:0] KIND_COMMENT   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd18;
    localparam logic [KIND_W-1:0] KIND_NEWLINE   = 5'd19;

    // character codes
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;

    // keyword table: if, else, while
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_CHARS] = '{
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{8'd2, 8'd4, 8'd5};
    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{KIND_IF, KIND_ELSE, KIND_WHILE};

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [POS_W-1:0]  token_start;
        logic [LEN_W-1:0]  token_length;
        logic              last_of_run;
    } token_item_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] len);
        return (len < LEN_MAX) ? len + 1'b1 : LEN_MAX;
    endfunction

    // drop keyword candidates that do not match c at position idx
    function automatic logic [KW_COUNT-1:0] kw_next(input logic [KW_COUNT-1:0] m,
                                                    input logic [LEN_W-1:0]    idx,
                                                    input logic [7:0]          c);
        logic [KW_COUNT-1:0] r;
        logic                hit;
        r = m;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = 1'b0;
            if (idx < KW_LEN[k])
                hit = (KW_TEXT[k][idx[2:0]] == c);
            if (!hit)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] word_kind(input logic [KW_COUNT-1:0] m,
                                                    input logic [LEN_W-1:0]    len);
        logic [KIND_W-1:0] kind;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (m[k] && (len == KW_LEN[k]))
                kind = KW_KIND[k];
        end
        return kind;
    endfunction

    function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
        logic [KIND_W-1:0] kind;
        case (c)
            8'h3D:      kind = KIND_ASSIGN;
            8'h2B:      kind = KIND_PLUS;
            8'h2D:      kind = KIND_MINUS;
            8'h2A:      kind = KIND_MUL;
            8'h28:      kind = KIND_LPAREN;
            8'h29:      kind = KIND_RPAREN;
            8'h7B:      kind = KIND_LBRACE;
            8'h7D:      kind = KIND_RBRACE;
            8'h2C:      kind = KIND_COMMA;
            8'h3B:      kind = KIND_SEMICOLON;
            CH_NEWLINE: kind = KIND_NEWLINE;
            default:    kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

    function automatic token_item_t make_token(input logic [KIND_W-1:0] kind,
                                               input logic [POS_W-1:0]  start,
                                               input logic [LEN_W-1:0]  len);
        token_item_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lexical_tokenizer_core.sv =====
// lexical tokenizer top level: byte scanner state machine and token output queue
// depends on lex_tok_pkg
//
//  channel  | direction | payload        | transfer
//  ---------+-----------+----------------+----------------------------------
//  char     | in        | char_item_t    | one source byte, last-byte flag
//  token    | out       | token_item_t   | one token: kind, start, length
//
// one byte is scanned per cycle; a byte that causes no token or one token is
// taken every cycle while the token side keeps up
// a byte that causes two tokens holds the char side until the first one leaves:
// the two-entry token queue drains one token per cycle with token_ready high
// reset clears the scanner to idle, position 0, and empties the queue
// char_ready drops while the token queue holds two tokens, or holds one token
// that cannot leave this cycle
`timescale 1ns / 1ps
`default_nettype none

module lexical_tokenizer_core
    import lex_tok_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             char_valid,
    output logic            char_ready,
    input  wire char_item_t char_item,
    output logic            token_valid,
    input  wire             token_ready,
    output token_item_t     token_item
);

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_SLASH   = 5'b01000,
        MODE_COMMENT = 5'b10000
    } scan_mode_t;

    // scanner state
    scan_mode_t          mode_reg,   mode_next;
    logic [POS_W-1:0]    start_reg,  start_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [KW_COUNT-1:0] kwm_reg,    kwm_next;
    logic                dot_reg,    dot_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;

    // token queue
    token_item_t         tok0_reg,   tok0_next;
    token_item_t         tok1_reg,   tok1_next;
    logic [1:0]          cnt_reg,    cnt_next;

    logic                char_fire;
    logic                pop;
    logic [7:0]          c;

    // closing token of the open lexeme, a one-byte symbol, end-of-text flush
    token_item_t         tok_a, tok_b, tok_c;
    logic                a_v, b_v, c_v;
    logic                run_idle;

    token_item_t         first_tok, second_tok;
    logic [1:0]          n_tok;

    assign c           = char_item.char_code;
    assign token_valid = (cnt_reg != 2'd0);
    assign token_item  = tok0_reg;
    assign pop         = token_valid && token_ready;
    // room for two tokens once the queue head leaves
    assign char_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_ready);
    assign char_fire   = char_valid && char_ready;

    // scanner next state and tokens caused by the current byte
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kwm_next   = kwm_reg;
        dot_next   = dot_reg;
        pos_next   = pos_reg;
        tok_a      = make_token(KIND_ERROR, start_reg, len_reg);
        tok_b      = make_token(KIND_ERROR, pos_reg, 8'd1);
        tok_c      = make_token(KIND_ERROR, start_reg, len_reg);
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        run_idle   = 1'b0;

        unique case (mode_reg)
            MODE_WORD:
            begin
                if (is_letter(c) || is_digit(c) || (c == CH_UNDERSCORE))
                begin
                    kwm_next = kw_next(kwm_reg, len_reg, c);
                    len_next = sat_inc(len_reg);
                end
                else
                begin
                    tok_a    = make_token(word_kind(kwm_reg, len_reg), start_reg, len_reg);
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(c))
                    len_next = sat_inc(len_reg);
                else if ((c == CH_DOT) && !dot_reg)
                begin
                    dot_next = 1'b1;
                    len_next = sat_inc(len_reg);
                end
                else if (is_letter(c))
                begin
                    // the letter joins the error token and also opens a word
                    tok_a    = make_token(KIND_ERROR, start_reg, sat_inc(len_reg));
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
                else
                begin
                    tok_a    = make_token(dot_reg ? KIND_FLOAT : KIND_INT, start_reg, len_reg);
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                    len_next  = 8'd2;
                end
                else
                begin
                    tok_a    = make_token(KIND_DIV, start_reg, 8'd1);
                    a_v      = 1'b1;
                    run_idle = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                len_next = sat_inc(len_reg);
                if (c == CH_NEWLINE)
                begin
                    tok_a     = make_token(KIND_COMMENT, start_reg, len_next);
                    a_v       = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            default:
                run_idle = 1'b1;
        endcase

        // idle scan: skip a blank, start a lexeme or emit a one-byte token
        if (run_idle)
        begin
            mode_next = MODE_IDLE;
            if ((c == CH_SPACE) || (c == CH_TAB))
                mode_next = MODE_IDLE;
            else if (is_letter(c))
            begin
                mode_next  = MODE_WORD;
                start_next = pos_reg;
                kwm_next   = kw_next({KW_COUNT{1'b1}}, '0, c);
                len_next   = 8'd1;
            end
            else if (is_digit(c) || (c == CH_DOT))
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = 8'd1;
                dot_next   = (c == CH_DOT);
            end
            else if (c == CH_SLASH)
            begin
                mode_next  = MODE_SLASH;
                start_next = pos_reg;
                len_next   = 8'd1;
            end
            else
            begin
                tok_b = make_token(symbol_kind(c), pos_reg, 8'd1);
                b_v   = 1'b1;
            end
        end

        // end of text closes whatever lexeme is open
        if (char_item.end_of_text)
        begin
            unique case (mode_next)
                MODE_WORD:
                begin
                    tok_c = make_token(word_kind(kwm_next, len_next), start_next, len_next);
                    c_v   = 1'b1;
                end
                MODE_NUMBER:
                begin
                    tok_c = make_token(dot_next ? KIND_FLOAT : KIND_INT, start_next, len_next);
                    c_v   = 1'b1;
                end
                MODE_SLASH:
                begin
                    tok_c = make_token(KIND_DIV, start_next, 8'd1);
                    c_v   = 1'b1;
                end
                MODE_COMMENT:
                begin
                    tok_c = make_token(KIND_COMMENT, start_next, len_next);
                    c_v   = 1'b1;
                end
                default:
                    c_v = 1'b0;
            endcase
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
            pos_next = pos_reg + 1'b1;
    end

    // order the tokens: symbol and flush never come from the same byte
    always_comb
    begin
        second_tok = b_v ? tok_b : tok_c;
        if (a_v)
        begin
            first_tok = tok_a;
            n_tok     = (b_v || c_v) ? 2'd2 : 2'd1;
        end
        else
        begin
            first_tok = b_v ? tok_b : tok_c;
            n_tok     = (b_v || c_v) ? 2'd1 : 2'd0;
        end
        first_tok.last_of_run  = (n_tok == 2'd1);
        second_tok.last_of_run = 1'b1;
    end

    // token queue: head is presented, the second entry moves up on a transfer
    always_comb
    begin
        cnt_next  = cnt_reg;
        tok0_next = tok0_reg;
        tok1_next = tok1_reg;
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                tok0_next = tok1_reg;
                cnt_next  = 2'd1;
            end
            else
                cnt_next = 2'd0;
        end
        if (char_fire && (n_tok != 2'd0))
        begin
            tok0_next = first_tok;
            tok1_next = second_tok;
            cnt_next  = n_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            kwm_reg   <= {KW_COUNT{1'b1}};
            dot_reg   <= 1'b0;
            pos_reg   <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (char_fire)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                kwm_reg   <= kwm_next;
                dot_reg   <= dot_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // token payload, no reset needed
    always_ff @(posedge clk)
    begin
        tok0_reg <= tok0_next;
        tok1_reg <= tok1_next;
    end

endmodule

`default_nettype wire

// ===== hdl/lex_tok_checker.sv =====
// port-level checks for the lexical tokenizer, bound to its top level
// depends on lex_tok_pkg and lexical_tokenizer_core
`timescale 1ns / 1ps
`default_nettype none

module lex_tok_checker
    import lex_tok_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              char_valid,
    input wire              char_ready,
    input wire char_item_t  char_item,
    input wire              token_valid,
    input wire              token_ready,
    input wire token_item_t token_item
);

    // a stalled token holds
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !token_ready) |=> (token_valid && $stable(token_item)))
        else $error("token changed while stalled");

    // tokens appear only after a byte transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!token_valid && !(char_valid && char_ready)) |=> !token_valid)
        else $error("token appeared without a byte");

    // the byte side stalls only behind a pending token
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> token_valid)
        else $error("char side stalled with empty queue");

    // keywords carry their own lengths
    a_keyword_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |->
            ((token_item.token_kind != KIND_IF)    || (token_item.token_length == 8'd2)) &&
            ((token_item.token_kind != KIND_ELSE)  || (token_item.token_length == 8'd4)) &&
            ((token_item.token_kind != KIND_WHILE) || (token_item.token_length == 8'd5)))
        else $error("keyword token with wrong length");

    // lengths stay in range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> ((token_item.token_length != 8'd0) &&
                         (token_item.token_length <= LEN_MAX)))
        else $error("token length out of range");

endmodule

bind lexical_tokenizer_core lex_tok_checker u_lex_tok_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_item   (char_item),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_item  (token_item)
);

`default_nettype wire
